[hdl/fee_pkg.sv]
package fee_pkg;

    // default sizes
    localparam int NUM_VARS_DEF   = 64;
    localparam int PART_WORDS_DEF = 256;

    // flash word codes
    localparam logic [31:0] ERASED_WORD   = 32'hffff_ffff;
    localparam logic [31:0] USED_MARK_RST = 32'h5555_5555;

    // partition code for none selected
    localparam logic [1:0] PART_NONE = 2'd2;

    // status codes
    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_REJ = 1'b1;

    // register index of the used mark
    localparam logic REG_USED_MARK = 1'b0;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_FORMAT = 2'd2,
        OP_INIT   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [15:0] data;
    } fee_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        status;
        logic [1:0]  active_partition;
    } fee_out_t;

endpackage

[hdl/fee_ram.sv]
module fee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[hdl/fee_seq.sv]
module fee_seq
    import fee_pkg::*;
#(
    parameter int NUM_VARS   = NUM_VARS_DEF,
    parameter int PART_WORDS = PART_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] used_mark,
    input  logic        s_valid,
    output logic        s_ready,
    input  fee_in_t     s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output fee_out_t    m_item
);

    localparam int VA_W    = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int PI_W    = $clog2(PART_WORDS);
    localparam int FA_W    = $clog2(2 * PART_WORDS);
    localparam int CNT_LIM = (2 * PART_WORDS > NUM_VARS) ? 2 * PART_WORDS : NUM_VARS;
    localparam int CNT_W   = $clog2(CNT_LIM);

    typedef enum logic [14:0] {
        S_CLR_F   = 15'h0001,
        S_CLR_S   = 15'h0002,
        S_IDLE    = 15'h0004,
        S_RD      = 15'h0008,
        S_WR_CHK  = 15'h0010,
        S_WR_LAST = 15'h0020,
        S_WR_SCAN = 15'h0040,
        S_INI_0   = 15'h0080,
        S_INI_1   = 15'h0100,
        S_CMP_RD  = 15'h0200,
        S_CMP_WR  = 15'h0400,
        S_ERASE   = 15'h0800,
        S_LD_RD   = 15'h1000,
        S_LD      = 15'h2000,
        S_DONE    = 15'h4000
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]     addr_reg, addr_next;
    logic [15:0]     data_reg, data_next;
    logic [1:0]      piu_reg, piu_next;
    logic            tgt_reg, tgt_next;
    logic            ers_reg, ers_next;
    logic            post_erase_reg, post_erase_next;
    logic            fmt_reg, fmt_next;
    logic [15:0]     rd_reg, rd_next;
    logic            st_reg, st_next;
    fee_out_t        out_reg, out_next;
    logic            m_valid_reg, m_valid_next;

    logic            f_we;
    logic [FA_W-1:0] f_addr;
    logic [31:0]     f_wdata, f_rdata;
    logic            s_we;
    logic [VA_W-1:0] s_addr;
    logic [15:0]     s_wdata, s_rdata;

    logic            in_ok;
    logic            rec_ok;
    logic            ld_ok;
    logic [CNT_W-1:0] jm1;
    logic [PI_W-1:0] scan_k;

    function automatic logic [FA_W-1:0] faddr(input logic part, input logic [PI_W-1:0] idx);
        faddr = part ? (FA_W'(PART_WORDS) + FA_W'(idx)) : FA_W'(idx);
    endfunction

    // flash store and shadow copy
    fee_ram #(.WIDTH(32), .DEPTH(2 * PART_WORDS), .AW(FA_W)) u_flash (
        .aclk  (aclk),
        .we    (f_we),
        .addr  (f_addr),
        .wdata (f_wdata),
        .rdata (f_rdata)
    );

    fee_ram #(.WIDTH(16), .DEPTH(NUM_VARS), .AW(VA_W)) u_shadow (
        .aclk  (aclk),
        .we    (s_we),
        .addr  (s_addr),
        .wdata (s_wdata),
        .rdata (s_rdata)
    );

    // range checks
    assign in_ok  = {1'b0, s_item.address} < 17'(NUM_VARS);
    assign jm1    = cnt_reg - CNT_W'(1);
    assign rec_ok = (cnt_reg != '0) && ({1'b0, jm1} < (CNT_W + 1)'(NUM_VARS));
    assign ld_ok  = {1'b0, f_rdata[31:16]} < 17'(NUM_VARS);
    assign scan_k = (f_rdata != ERASED_WORD) ? cnt_reg[PI_W-1:0] : '0;

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        piu_next        = piu_reg;
        tgt_next        = tgt_reg;
        ers_next        = ers_reg;
        post_erase_next = post_erase_reg;
        fmt_next        = fmt_reg;
        rd_next         = rd_reg;
        st_next         = st_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        f_we            = 1'b0;
        f_addr          = '0;
        f_wdata         = ERASED_WORD;
        s_we            = 1'b0;
        s_addr          = '0;
        s_wdata         = '0;

        case (state_reg)
            S_CLR_F: begin
                f_we   = 1'b1;
                f_addr = cnt_reg[FA_W-1:0];
                if (cnt_reg == CNT_W'(2 * PART_WORDS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_CLR_S;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_CLR_S: begin
                s_we   = 1'b1;
                s_addr = cnt_reg[VA_W-1:0];
                if (cnt_reg == CNT_W'(NUM_VARS - 1)) begin
                    cnt_next = '0;
                    if (fmt_reg) begin
                        fmt_next        = 1'b0;
                        tgt_next        = 1'b0;
                        ers_next        = 1'b1;
                        post_erase_next = 1'b1;
                        state_next      = S_CMP_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    addr_next = s_item.address;
                    data_next = s_item.data;
                    rd_next   = '0;
                    st_next   = STAT_OK;
                    case (op_t'(s_item.operation))
                        OP_READ: begin
                            s_addr = s_item.address[VA_W-1:0];
                            if (in_ok) begin
                                state_next = S_RD;
                            end else begin
                                st_next    = STAT_REJ;
                                state_next = S_DONE;
                            end
                        end
                        OP_WRITE: begin
                            s_addr = s_item.address[VA_W-1:0];
                            if (piu_reg == PART_NONE || !in_ok) begin
                                st_next    = STAT_REJ;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_WR_CHK;
                            end
                        end
                        OP_FORMAT: begin
                            cnt_next   = '0;
                            fmt_next   = 1'b1;
                            state_next = S_CLR_S;
                        end
                        OP_INIT: begin
                            f_addr     = faddr(1'b0, '0);
                            state_next = S_INI_0;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD: begin
                rd_next    = s_rdata;
                state_next = S_DONE;
            end
            S_WR_CHK: begin
                if (s_rdata == data_reg) begin
                    state_next = S_DONE;
                end else begin
                    f_addr     = faddr(piu_reg[0], PI_W'(PART_WORDS - 1));
                    state_next = S_WR_LAST;
                end
            end
            S_WR_LAST: begin
                if (f_rdata != ERASED_WORD) begin
                    // partition full: update shadow, then compact into the other one
                    s_we            = 1'b1;
                    s_addr          = addr_reg[VA_W-1:0];
                    s_wdata         = data_reg;
                    tgt_next        = ~piu_reg[0];
                    ers_next        = piu_reg[0];
                    post_erase_next = 1'b1;
                    cnt_next        = '0;
                    state_next      = S_CMP_RD;
                end else begin
                    cnt_next   = CNT_W'(PART_WORDS - 2);
                    f_addr     = faddr(piu_reg[0], PI_W'(PART_WORDS - 2));
                    state_next = S_WR_SCAN;
                end
            end
            S_WR_SCAN: begin
                // backward scan for the last used word
                if (f_rdata != ERASED_WORD || cnt_reg == CNT_W'(1)) begin
                    f_we       = 1'b1;
                    f_addr     = faddr(piu_reg[0], scan_k + PI_W'(1));
                    f_wdata    = {addr_reg, data_reg};
                    s_we       = 1'b1;
                    s_addr     = addr_reg[VA_W-1:0];
                    s_wdata    = data_reg;
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    f_addr   = faddr(piu_reg[0], jm1[PI_W-1:0]);
                end
            end
            S_INI_0: begin
                if (f_rdata == used_mark) begin
                    piu_next   = 2'd0;
                    state_next = S_LD_RD;
                end else begin
                    f_addr     = faddr(1'b1, '0);
                    state_next = S_INI_1;
                end
            end
            S_INI_1: begin
                if (f_rdata == used_mark) begin
                    piu_next   = 2'd1;
                    state_next = S_LD_RD;
                end else begin
                    tgt_next        = 1'b0;
                    post_erase_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                s_addr     = jm1[VA_W-1:0];
                state_next = S_CMP_WR;
            end
            S_CMP_WR: begin
                // mark in word 0, one record per variable, rest erased
                f_we   = 1'b1;
                f_addr = faddr(tgt_reg, cnt_reg[PI_W-1:0]);
                if (cnt_reg == '0) begin
                    f_wdata = used_mark;
                end else if (rec_ok) begin
                    f_wdata = {16'(jm1), s_rdata};
                end else begin
                    f_wdata = ERASED_WORD;
                end
                if (cnt_reg == CNT_W'(PART_WORDS - 1)) begin
                    piu_next   = {1'b0, tgt_reg};
                    cnt_next   = '0;
                    state_next = post_erase_reg ? S_ERASE : S_LD_RD;
                end else begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_CMP_RD;
                end
            end
            S_ERASE: begin
                f_we   = 1'b1;
                f_addr = faddr(ers_reg, cnt_reg[PI_W-1:0]);
                if (cnt_reg == CNT_W'(PART_WORDS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_LD_RD: begin
                cnt_next   = CNT_W'(1);
                f_addr     = faddr(piu_reg[0], PI_W'(1));
                state_next = S_LD;
            end
            S_LD: begin
                // forward pass, newer records overwrite older ones
                if (ld_ok) begin
                    s_we    = 1'b1;
                    s_addr  = f_rdata[VA_W+15:16];
                    s_wdata = f_rdata[15:0];
                end
                if (cnt_reg == CNT_W'(PART_WORDS - 1)) begin
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    f_addr   = faddr(piu_reg[0], cnt_reg[PI_W-1:0] + PI_W'(1));
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.read_data        = rd_reg;
                    out_next.status           = st_reg;
                    out_next.active_partition = piu_reg;
                    m_valid_next              = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR_F;
            cnt_reg     <= '0;
            piu_reg     <= PART_NONE;
            fmt_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            piu_reg     <= piu_next;
            fmt_reg     <= fmt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        data_reg       <= data_next;
        tgt_reg        <= tgt_next;
        ers_reg        <= ers_next;
        post_erase_reg <= post_erase_next;
        rd_reg         <= rd_next;
        st_reg         <= st_next;
        out_reg        <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule

[hdl/flash_eeprom_emulator.sv]
// an appending write scans backward for the last used word, one flash word a cycle on the
// single flash port; a compacting write and a blank init copy the shadow word by word into a
// partition, and a format first zeroes the shadow; one item at a time, a result waits in an
// output register while the next item is taken
// reset: synchronous active low; afterwards a clearing pass erases the flash store and
// zeroes the shadow copy before the first item is taken
module flash_eeprom_emulator
    import fee_pkg::*;
#(
    parameter int NUM_VARS   = NUM_VARS_DEF,
    parameter int PART_WORDS = PART_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  fee_in_t     s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output fee_out_t    m_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] used_mark_reg, used_mark_next;
    logic        reg_hit;

    // configuration register
    assign reg_hit = (paddr[2] == REG_USED_MARK);

    always_comb begin
        used_mark_next = used_mark_reg;
        if (psel && penable && pwrite && reg_hit) begin
            used_mark_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_mark_reg <= USED_MARK_RST;
        end else begin
            used_mark_reg <= used_mark_next;
        end
    end

    assign prdata = reg_hit ? used_mark_reg : '0;
    assign pready = 1'b1;

    fee_seq #(
        .NUM_VARS   (NUM_VARS),
        .PART_WORDS (PART_WORDS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .used_mark (used_mark_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

[tb/sv/fee_checker.sv]
`timescale 1ns / 100ps

// watches both channels and the register port, predicts each result and compares
module fee_checker
    import fee_pkg::*;
#(
    parameter int NUM_VARS   = NUM_VARS_DEF,
    parameter int PART_WORDS = PART_WORDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  fee_in_t     s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  fee_out_t    m_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    // own copy of the emulator state
    logic [15:0] shadow [NUM_VARS];
    logic [31:0] flash [2*PART_WORDS];
    logic [1:0]  cur_part;
    logic [31:0] mark;
    fee_out_t    expected_q[$];

    function automatic int base_of(logic [1:0] p);
        return p[0] ? PART_WORDS : 0;
    endfunction

    function automatic void erase_part(logic [1:0] p);
        int b;
        b = base_of(p);
        for (int i = 0; i < PART_WORDS; i++) flash[b+i] = ERASED_WORD;
    endfunction

    // rewrite the whole shadow into one partition, then stamp it
    function automatic void compact_into(logic [1:0] p);
        int b;
        b = base_of(p);
        erase_part(p);
        for (int i = 0; i < NUM_VARS; i++) begin
            if (i + 1 < PART_WORDS) flash[b+i+1] = {16'(i), shadow[i]};
        end
        flash[b] = mark;
    endfunction

    // newest record of each variable wins
    function automatic void rebuild_shadow();
        int b;
        b = base_of(cur_part);
        for (int v = 0; v < NUM_VARS; v++) begin
            for (int k = PART_WORDS - 1; k > 0; k--) begin
                if (flash[b+k][31:16] == 16'(v)) begin
                    shadow[v] = flash[b+k][15:0];
                    break;
                end
            end
        end
    endfunction

    function automatic void store_value(int a, logic [15:0] val);
        logic [1:0] c;
        int b;
        int k;
        c = {1'b0, cur_part[0]};
        b = base_of(c);
        if (flash[b+PART_WORDS-1] != ERASED_WORD) begin
            shadow[a] = val;
            compact_into(c ^ 2'd1);
            cur_part = c ^ 2'd1;
            erase_part(c);
        end else begin
            for (k = PART_WORDS - 2; k > 0; k--) begin
                if (flash[b+k] != ERASED_WORD) break;
            end
            flash[b+k+1] = {16'(a), val};
            shadow[a] = val;
        end
    endfunction

    function automatic fee_out_t emulate(fee_in_t it);
        fee_out_t r;
        r = '0;
        r.status = STAT_OK;
        case (op_t'(it.operation))
            OP_READ: begin
                if (it.address < NUM_VARS) r.read_data = shadow[it.address];
                else r.status = STAT_REJ;
            end
            OP_WRITE: begin
                if (cur_part == PART_NONE || it.address >= NUM_VARS) r.status = STAT_REJ;
                else if (shadow[it.address] != it.data) store_value(it.address, it.data);
            end
            OP_FORMAT: begin
                for (int i = 0; i < NUM_VARS; i++) shadow[i] = '0;
                compact_into(2'd0);
                cur_part = 2'd0;
                erase_part(2'd1);
            end
            default: begin
                if (flash[0] == mark) cur_part = 2'd0;
                else if (flash[PART_WORDS] == mark) cur_part = 2'd1;
                else begin
                    compact_into(2'd0);
                    cur_part = 2'd0;
                end
                rebuild_shadow();
            end
        endcase
        r.active_partition = cur_part;
        return r;
    endfunction

    always @(posedge aclk) begin
        fee_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_VARS; i++) shadow[i] = '0;
            for (int i = 0; i < 2*PART_WORDS; i++) flash[i] = ERASED_WORD;
            cur_part = PART_NONE;
            mark = USED_MARK_RST;
            expected_q.delete();
            fail_count = 0;
            results_seen = 0;
        end else begin
            // register write
            if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_USED_MARK))
                mark = pwdata;
            // accepted item
            if (s_valid && s_ready) expected_q.push_back(emulate(s_item));
            // accepted result
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %p", m_item);
                end else begin
                    want = expected_q.pop_front();
                    if (want.read_data != m_item.read_data || want.status != m_item.status
                        || want.active_partition != m_item.active_partition) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at result %0d: expected %p, got %p",
                                     results_seen, want, m_item);
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import fee_pkg::*;

    localparam int NV       = NUM_VARS_DEF;
    localparam int PW       = PART_WORDS_DEF;
    localparam int SETTLE   = 3 * PW + 64;
    localparam int LIMIT    = 6000000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    fee_in_t     s_item;
    logic        m_valid;
    logic        m_ready;
    fee_out_t    m_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int results_seen;
    int idle_pct;
    int cycles;
    int items_sent;
    int hold_left;
    logic hold_req;
    logic hold_done;

    flash_eeprom_emulator #(.NUM_VARS(NV), .PART_WORDS(PW)) i_dut (.*);

    fee_checker #(.NUM_VARS(NV), .PART_WORDS(PW)) i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_item, .m_valid, .m_ready, .m_item,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fail_count, .pending, .results_seen
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 3000;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    task automatic send(fee_in_t it);
        logic rdy;
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        items_sent++;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
    endtask

    task automatic send_op(op_t op, logic [15:0] a, logic [15:0] d);
        fee_in_t it;
        it.operation = op;
        it.address = a;
        it.data = d;
        send(it);
    endtask

    // drain everything, let a quiet block finish, then write the used mark
    task automatic set_mark(logic [31:0] v);
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(4 * REG_USED_MARK);
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_item(int narrow);
        int sel;
        fee_in_t it;
        sel = $urandom_range(0, 99);
        if (sel < 30) it.operation = OP_READ;
        else if (sel < 92) it.operation = OP_WRITE;
        else if (sel < 94) it.operation = OP_FORMAT;
        else it.operation = OP_INIT;
        sel = $urandom_range(0, 99);
        if (sel < 8) it.address = 16'($urandom);
        else if (sel < 11) it.address = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'(NV);
        else if (narrow != 0) it.address = 16'($urandom_range(0, 7));
        else it.address = 16'($urandom_range(0, NV - 1));
        sel = $urandom_range(0, 99);
        if (sel < 50) it.data = 16'($urandom);
        else if (sel < 60) it.data = 16'hffff;
        else it.data = 16'($urandom_range(0, 2));
        send(it);
    endtask

    initial begin
        logic [31:0] marks [4];
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        items_sent = 0;
        idle_pct = 31;
        hold_req = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: behaviour before init, range edges, unchanged writes, format
        send_op(OP_READ,   16'd5,      16'h0);
        send_op(OP_WRITE,  16'd5,      16'h1234);
        send_op(OP_READ,   16'hffff,   16'h0);
        send_op(OP_INIT,   16'hffff,   16'hffff);
        send_op(OP_WRITE,  16'd0,      16'hffff);
        send_op(OP_WRITE,  16'(NV-1),  16'h8001);
        send_op(OP_WRITE,  16'(NV-1),  16'h8001);
        send_op(OP_WRITE,  16'd3,      16'h0);
        send_op(OP_WRITE,  16'(NV),    16'h5a5a);
        send_op(OP_WRITE,  16'hffff,   16'ha5a5);
        send_op(OP_READ,   16'd0,      16'h0);
        send_op(OP_READ,   16'(NV-1),  16'hffff);
        send_op(OP_READ,   16'(NV),    16'h0);
        send_op(OP_INIT,   16'd0,      16'h0);
        send_op(OP_READ,   16'(NV-1),  16'h0);
        send_op(OP_FORMAT, 16'h1234,   16'h4321);
        send_op(OP_READ,   16'(NV-1),  16'h0);
        send_op(OP_WRITE,  16'd7,      16'h0007);
        send_op(OP_INIT,   16'd0,      16'h0);
        send_op(OP_READ,   16'd7,      16'h0);

        // random phases, each under its own used mark
        marks[0] = USED_MARK_RST;
        marks[1] = 32'h0;
        marks[2] = 32'hffff_fffe;
        marks[3] = $urandom_range(1, 32'hffff_fffd);
        for (int ph = 0; ph < 4; ph++) begin
            set_mark(marks[ph]);
            // new mark from phase 1: init finds no partition, reformats keeping shadow
            send_op(OP_INIT, 16'h0, 16'h0);
            for (int n = 0; n < 380; n++) begin
                if (ph == 1 && n == 40) hold_req <= 1'b1;
                idle_pct = (ph == 2 && n >= 100 && n < 250) ? 0 : 31;
                random_item((ph == 1 || ph == 3) ? 1 : 0);
            end
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d items and %0d results over four used marks", items_sent,
                 results_seen);
        $display("with random stalls, a quiet stretch and one long result hold-off");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/fee_pkg.sv
hdl/fee_ram.sv
hdl/fee_seq.sv
hdl/flash_eeprom_emulator.sv
tb/sv/fee_checker.sv
tb/sv/tb.sv
